### sv/covalent_bond_detector_assert.svh
// Assertion macros used by the checker of the bond detector
`ifndef COVALENT_BOND_DETECTOR_ASSERT_SVH
`define COVALENT_BOND_DETECTOR_ASSERT_SVH

// same-cycle implication, quiet in reset
`define CBD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet in reset
`define CBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/cbd_pkg.sv
// Types and constants shared by the bond detector modules
`default_nettype none

package cbd_pkg;

  localparam int MAX_ATOMS = 64;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = $clog2(MAX_ATOMS + 1);
  localparam int ADDR_W    = $clog2(MAX_ATOMS);
  localparam int COORD_W   = 32;
  localparam int RAD_W     = 20;
  localparam int TOL_W     = 20;
  localparam int PADDR_W   = 3;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(6554);
  localparam logic [20:0]      ONE_Q16   = 21'h10000;

  // register index, taken from paddr[2]
  localparam logic REG_TOLERANCE = 1'b0;

  typedef struct packed {
    logic                      first;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic        [RAD_W-1:0]   radius;
  } atom_t;

  typedef struct packed {
    logic [IDX_W-1:0] earlier_atom;
    logic [IDX_W-1:0] new_atom;
    logic             dropped;
    logic             last;
  } bond_t;

  // one stored atom
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic        [RAD_W-1:0]   r;
  } entry_t;

  typedef struct packed {
    logic start;
  } pair_ctl_t;

  typedef struct packed {
    logic done;
    logic bonded;
  } pair_sts_t;

endpackage

`default_nettype wire

### sv/cbd_atom_mem.sv
// Atom store: one write port, one registered read port
`default_nettype none

module cbd_atom_mem
  import cbd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire entry_t            wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output      entry_t            rd_data
);

  entry_t mem [MAX_ATOMS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### sv/cbd_pair_unit.sv
// Pair test on one shared 32x32 multiplier: d2 * 2^32 <= ((1+tau)(ri+rj))^2
`default_nettype none

module cbd_pair_unit
  import cbd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire pair_ctl_t        ctl,
  input  wire entry_t           cur,
  input  wire entry_t           stored,
  input  wire logic [TOL_W-1:0] tolerance,
  output      pair_sts_t        sts
);

  typedef enum logic [3:0] {
    P_IDLE, P_DIFF, P_MXX, P_MYY, P_MZZ, P_MRAD, P_MHH, P_MHL, P_MLL, P_ACC, P_CMP
  } pstate_t;

  pstate_t     state;
  logic [31:0] dx, dy, dz;
  logic [20:0] rsum, tolf;
  logic [63:0] prod;
  logic [65:0] d2;
  logic [41:0] m;
  logic [83:0] m2;
  logic [31:0] mul_a, mul_b;

  function automatic logic [31:0] abs_diff(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    return d[32] ? 32'(-d) : d[31:0];
  endfunction

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      P_MXX:   begin mul_a = dx; mul_b = dx; end
      P_MYY:   begin mul_a = dy; mul_b = dy; end
      P_MZZ:   begin mul_a = dz; mul_b = dz; end
      P_MRAD:  begin mul_a = 32'(rsum); mul_b = 32'(tolf); end
      P_MHH:   begin mul_a = 32'(prod[41:21]); mul_b = 32'(prod[41:21]); end
      P_MHL:   begin mul_a = 32'(m[41:21]); mul_b = 32'(m[20:0]); end
      P_MLL:   begin mul_a = 32'(m[20:0]); mul_b = 32'(m[20:0]); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (rst) begin
      state <= P_IDLE;
    end else begin
      case (state)
        P_IDLE: begin
          if (ctl.start) state <= P_DIFF;
        end
        P_DIFF: begin
          dx    <= abs_diff(cur.x, stored.x);
          dy    <= abs_diff(cur.y, stored.y);
          dz    <= abs_diff(cur.z, stored.z);
          rsum  <= 21'(cur.r) + 21'(stored.r);
          tolf  <= ONE_Q16 + 21'(tolerance);
          state <= P_MXX;
        end
        P_MXX: state <= P_MYY;
        P_MYY: begin
          d2    <= 66'(prod);
          state <= P_MZZ;
        end
        P_MZZ: begin
          d2    <= d2 + 66'(prod);
          state <= P_MRAD;
        end
        P_MRAD: begin
          d2    <= d2 + 66'(prod);
          state <= P_MHH;
        end
        P_MHH: begin
          m     <= prod[41:0];
          state <= P_MHL;
        end
        P_MHL: begin
          m2    <= {prod[41:0], 42'b0};
          state <= P_MLL;
        end
        P_MLL: begin
          // cross term counted twice: shift by 22, not 21
          m2    <= m2 + {20'b0, prod[41:0], 22'b0};
          state <= P_ACC;
        end
        P_ACC: begin
          m2    <= m2 + 84'(prod[41:0]);
          state <= P_CMP;
        end
        P_CMP:   state <= P_IDLE;
        default: state <= P_IDLE;
      endcase
    end
  end

  // low 32 bits of d2 * 2^32 are zero, so compare against m2 >> 32
  assign sts.done   = (state == P_CMP);
  assign sts.bonded = (d2 <= 66'(m2[83:32]));

endmodule

`default_nettype wire

### sv/covalent_bond_detector.sv
// Covalent-radius bond detector: top level with sequencer, output register and APB
//
//   channel  dir  handshake            word
//   atom     in   atom_valid/ready     atom_t: first, pos_x/y/z (Q15.16), radius (Q.16)
//   bond     out  bond_valid/ready     bond_t: earlier_atom, new_atom, dropped, last
//   apb      in   psel/penable/pready  reg 0 tolerance (Q.16), pready tied high
//
// Scan: each stored predecessor of an atom costs one store read, ten steps of
//   the shared multiplier unit (the differences, three squares, the radius
//   product, three partial products of m, the final sum and the compare) and
//   a step in T_EMIT to post the result. A dropped atom only passes T_DROP.
// Reset: rst is synchronous; it empties the store and sets tolerance to 0.10.
//   The store itself is not cleared; only entries below the count are read.
// Stalls: a bond is held back until its successor or the end of the scan is known,
//   so last can be set; the scan waits on a full output word only to push a held bond.
// atom_ready is high only between atoms; an atom may be taken while the last
//   bond of the previous one still sits in the output register.
`default_nettype none

module covalent_bond_detector
  import cbd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // APB configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output      logic [31:0]        prdata,
  output      logic               pready,
  // atom input
  input  wire logic               atom_valid,
  output      logic               atom_ready,
  input  wire atom_t              atom,
  // bond output
  output      logic               bond_valid,
  input  wire logic               bond_ready,
  output      bond_t              bond
);

  typedef enum logic [2:0] {
    T_IDLE, T_READ, T_WAIT, T_EMIT, T_FLUSH, T_DROP
  } tstate_t;

  tstate_t          state;
  logic [TOL_W-1:0] tolerance;
  logic [CNT_W-1:0] count;       // atoms in the store, 0..MAX_ATOMS
  logic [CNT_W-1:0] eff_count;   // count after a first flag
  logic             full;
  logic             take;
  logic [IDX_W-1:0] new_idx;     // index of the atom in flight
  logic [IDX_W-1:0] k;           // stored atom under test
  logic [IDX_W-1:0] pend_idx;    // bond held back for the last flag
  logic             pend_valid;
  logic             hit;
  entry_t           cur;
  entry_t           wr_data;
  entry_t           rd_data;
  pair_ctl_t        pctl;
  pair_sts_t        psts;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TOLERANCE) ? 32'(tolerance) : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TOLERANCE)) begin
      tolerance <= pwdata[TOL_W-1:0];
    end
  end

  // ---------------- input side ----------------
  assign atom_ready = (state == T_IDLE);
  assign take       = atom_valid && atom_ready;
  assign eff_count  = atom.first ? '0 : count;
  assign full       = (eff_count == CNT_W'(MAX_ATOMS));

  // the new atom goes into the store right away; the scan reads only below it
  assign wr_data.x = atom.pos_x;
  assign wr_data.y = atom.pos_y;
  assign wr_data.z = atom.pos_z;
  assign wr_data.r = atom.radius;

  cbd_atom_mem u_mem (
    .clk     (clk),
    .wr_en   (take && !full),
    .wr_addr (eff_count[ADDR_W-1:0]),
    .wr_data (wr_data),
    .rd_addr (ADDR_W'(k)),
    .rd_data (rd_data)
  );

  // the read is issued in T_READ; the unit picks up the registered data in the next cycle, in P_DIFF
  assign pctl.start = (state == T_READ);

  cbd_pair_unit u_pair (
    .clk       (clk),
    .rst       (rst),
    .ctl       (pctl),
    .cur       (cur),
    .stored    (rd_data),
    .tolerance (tolerance),
    .sts       (psts)
  );

  // ---------------- sequencer and output word ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= T_IDLE;
      count      <= '0;
      pend_valid <= 1'b0;
      bond_valid <= 1'b0;
    end else begin
      if (bond_valid && bond_ready) bond_valid <= 1'b0;

      case (state)
        T_IDLE: begin
          if (take) begin
            cur        <= wr_data;
            pend_valid <= 1'b0;
            k          <= '0;
            if (full) begin
              state <= T_DROP;
            end else begin
              count   <= eff_count + CNT_W'(1);
              new_idx <= eff_count[IDX_W-1:0];
              // first atom of a molecule has nothing to compare against
              state   <= (eff_count == '0) ? T_FLUSH : T_READ;
            end
          end
        end

        T_READ: state <= T_WAIT;

        T_WAIT: begin
          if (psts.done) begin
            hit   <= psts.bonded;
            state <= T_EMIT;
          end
        end

        T_EMIT: begin
          // a new hit pushes the held bond out, so it needs a free output word
          if (!(hit && pend_valid && bond_valid)) begin
            if (hit) begin
              if (pend_valid) begin
                bond_valid        <= 1'b1;
                bond.earlier_atom <= pend_idx;
                bond.new_atom     <= new_idx;
                bond.dropped      <= 1'b0;
                bond.last         <= 1'b0;
              end
              pend_idx   <= k;
              pend_valid <= 1'b1;
            end
            if (k == new_idx - IDX_W'(1)) begin
              state <= T_FLUSH;
            end else begin
              k     <= k + IDX_W'(1);
              state <= T_READ;
            end
          end
        end

        T_FLUSH: begin
          if (!pend_valid) begin
            state <= T_IDLE;
          end else if (!bond_valid) begin
            bond_valid        <= 1'b1;
            bond.earlier_atom <= pend_idx;
            bond.new_atom     <= new_idx;
            bond.dropped      <= 1'b0;
            bond.last         <= 1'b1;
            pend_valid        <= 1'b0;
            state             <= T_IDLE;
          end
        end

        T_DROP: begin
          if (!bond_valid) begin
            bond_valid        <= 1'b1;
            bond.earlier_atom <= '0;
            bond.new_atom     <= '0;
            bond.dropped      <= 1'b1;
            bond.last         <= 1'b1;
            state             <= T_IDLE;
          end
        end

        default: state <= T_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/cbd_checker.sv
// Port-level checker for the bond detector, bound to the top level
`default_nettype none

`include "covalent_bond_detector_assert.svh"

module cbd_checker
  import cbd_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst,
  input wire logic  atom_valid,
  input wire logic  atom_ready,
  input wire logic  bond_valid,
  input wire logic  bond_ready,
  input wire bond_t bond
);

  `CBD_ASSERT_NEXT(a_bond_hold, bond_valid && !bond_ready, bond_valid, "bond word withdrawn")
  `CBD_ASSERT_NEXT(a_bond_stable, bond_valid && !bond_ready, $stable(bond), "bond word changed")
  `CBD_ASSERT_NEXT(a_busy_after_take, atom_valid && atom_ready, !atom_ready, "ready after take")
  `CBD_ASSERT_NOW(a_drop_form, bond_valid && bond.dropped, bond.last && (bond.earlier_atom == '0) && (bond.new_atom == '0), "malformed drop word")
  `CBD_ASSERT_NOW(a_pair_order, bond_valid && !bond.dropped, bond.earlier_atom < bond.new_atom, "earlier index not below new index")

endmodule

bind covalent_bond_detector cbd_checker u_cbd_checker (
  .clk        (clk),
  .rst        (rst),
  .atom_valid (atom_valid),
  .atom_ready (atom_ready),
  .bond_valid (bond_valid),
  .bond_ready (bond_ready),
  .bond       (bond)
);

`default_nettype wire
